// ===== rtl/bcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bcsr_pkg
// Types and constants of the block compressed sparse row lookup unit.
// ----------------------------------------------------------------------------
package bcsr_pkg;

	localparam int NUM_BLOCK_ROWS = 64;
	localparam int STORE_BLOCKS   = 1024;
	localparam int BLOCK_DIM      = 3;
	localparam int BLK_ELEMS      = BLOCK_DIM * BLOCK_DIM;

	localparam int ROW_W   = 6;
	localparam int COL_W   = 6;
	localparam int VAL_W   = 64;
	localparam int BIDX_W  = 10;
	localparam int EIDX_W  = 4;
	localparam int CNT_W   = 11;
	localparam int RIDX_W  = (NUM_BLOCK_ROWS > 1) ? $clog2(NUM_BLOCK_ROWS) : 1;
	localparam int BADR_W  = (STORE_BLOCKS > 1) ? $clog2(STORE_BLOCKS) : 1;
	localparam int TOT_W   = $clog2(STORE_BLOCKS + 1);
	localparam int FILL_W  = $clog2(BLK_ELEMS + 1);
	localparam int EADR_W  = (STORE_BLOCKS * BLK_ELEMS > 1)
		? $clog2(STORE_BLOCKS * BLK_ELEMS) : 1;
	localparam int SRCH_W  = TOT_W + 1;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [1:0] ST_HIT  = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	localparam logic OP_PUSH   = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic             op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [BIDX_W-1:0] block_index;
		logic [EIDX_W-1:0] elem_index;
		logic [VAL_W-1:0]  elem_value;
		logic              last;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROWRD,
		S_SEARCH,
		S_COLRD,
		S_ELRD,
		S_ELEM,
		S_OUT
	} state_t;

endpackage

// ===== rtl/bcsr_if.sv =====
// ----------------------------------------------------------------------------
// bcsr_if
// Valid/ready channel carrying one request or response.
// ----------------------------------------------------------------------------
interface bcsr_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bcsr_block_store_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// bcsr_block_store_lookup_unit
// Block sparse row store: appends block elements, binary-searches a row.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | op, row, col, value
//  rsp     | out | status, block_index, elem_index, elem_value, last
//
//  Push: no response unless the store is full (overflow response); the push
//  that completes a block holds off requests while the row memory is
//  updated.
//  Lookup: the row read, then search steps that each wait on the column
//  memory read, then the element read is primed and each element is sent.
//  Row valid flags are cleared by arst_n; memories are not cleared.
//  A stalled response holds the sequencer; requests wait until it drains.
// ----------------------------------------------------------------------------
module bcsr_block_store_lookup_unit (
	input  logic clk,
	input  logic arst_n,
	bcsr_if.sink   req,
	bcsr_if.source rsp
);

	logic [bcsr_pkg::BIDX_W+bcsr_pkg::CNT_W-1:0] row_mem [bcsr_pkg::NUM_BLOCK_ROWS];
	logic [bcsr_pkg::COL_W-1:0]  col_mem   [bcsr_pkg::STORE_BLOCKS];
	logic [bcsr_pkg::VAL_W-1:0]  elem_mem  [bcsr_pkg::STORE_BLOCKS*bcsr_pkg::BLK_ELEMS];
	logic [bcsr_pkg::NUM_BLOCK_ROWS-1:0] row_vld_q;

	logic [bcsr_pkg::TOT_W-1:0]  total_q;
	logic [bcsr_pkg::FILL_W-1:0] fill_q;
	bcsr_pkg::state_t            state_q, state_d;
	bcsr_pkg::req_t              r;
	bcsr_pkg::rsp_t              out_q;
	logic                        out_v_q;

	logic [bcsr_pkg::COL_W-1:0]  key_q;
	logic [bcsr_pkg::BIDX_W+bcsr_pkg::CNT_W-1:0] row_rd_q;
	logic                        vld_rd_q;
	logic [bcsr_pkg::BIDX_W-1:0] first_rd;
	logic [bcsr_pkg::CNT_W-1:0]  cnt_cur, cnt_nxt;
	logic                        commit_s1;
	logic [bcsr_pkg::RIDX_W-1:0] row_s1;
	logic [bcsr_pkg::BIDX_W-1:0] total_s1;
	logic [bcsr_pkg::SRCH_W-1:0] lo_q, hi_q, mid;
	logic [bcsr_pkg::COL_W-1:0]  col_rd_q;
	logic [bcsr_pkg::VAL_W-1:0]  elem_rd_q;
	logic [bcsr_pkg::EADR_W-1:0] eaddr_q;
	logic [bcsr_pkg::EIDX_W-1:0] eidx_q;
	logic [bcsr_pkg::BADR_W-1:0] hit_q;
	logic [bcsr_pkg::SRCH_W-1:0] hi_calc;

	logic acc, full, row_ok, commit;

	function automatic logic [bcsr_pkg::SRCH_W-1:0] SRCH_W_ext(logic [bcsr_pkg::BIDX_W-1:0] v);
		return bcsr_pkg::SRCH_W'(v);
	endfunction
	function automatic logic [bcsr_pkg::SRCH_W-1:0] SRCH_W_cnt(logic [bcsr_pkg::CNT_W-1:0] v);
		return bcsr_pkg::SRCH_W'(v);
	endfunction
	function automatic logic [bcsr_pkg::SRCH_W-1:0] SRCH_W_tot(logic [bcsr_pkg::TOT_W-1:0] v);
		return bcsr_pkg::SRCH_W'(v);
	endfunction

	assign r      = req.data;
	assign acc    = req.valid && req.ready;
	assign full   = total_q >= bcsr_pkg::TOT_W'(bcsr_pkg::STORE_BLOCKS);
	assign row_ok = 32'(r.row) < bcsr_pkg::NUM_BLOCK_ROWS;
	assign commit = acc && r.op == bcsr_pkg::OP_PUSH && !full
		&& 32'(fill_q) == bcsr_pkg::BLK_ELEMS - 1;
	assign first_rd  = row_rd_q[bcsr_pkg::CNT_W +: bcsr_pkg::BIDX_W];
	assign cnt_cur   = vld_rd_q ? row_rd_q[bcsr_pkg::CNT_W-1:0] : '0;
	assign cnt_nxt   = (cnt_cur != bcsr_pkg::COUNT_MAX) ? cnt_cur + 1'b1 : cnt_cur;
	assign mid       = (lo_q + hi_q) >> 1;
	assign hi_calc   = (SRCH_W_ext(first_rd) + SRCH_W_cnt(cnt_cur) > SRCH_W_tot(total_q))
		? SRCH_W_tot(total_q) : SRCH_W_ext(first_rd) + SRCH_W_cnt(cnt_cur);

	always_comb begin
		req.ready = state_q == bcsr_pkg::S_IDLE && !out_v_q && !commit_s1;
		rsp.valid = out_v_q;
		rsp.data  = out_q;
	end

	// memories
	always_ff @(posedge clk) begin
		if (acc && r.op == bcsr_pkg::OP_PUSH && !full)
			elem_mem[bcsr_pkg::EADR_W'(total_q * bcsr_pkg::BLK_ELEMS + 32'(fill_q))]
				<= r.value;
		elem_rd_q <= elem_mem[eaddr_q];
	end

	always_ff @(posedge clk) begin
		if (commit)
			col_mem[bcsr_pkg::BADR_W'(total_q)] <= r.col;
		col_rd_q <= col_mem[bcsr_pkg::BADR_W'(mid)];
	end

	always_ff @(posedge clk) begin
		if (commit_s1)
			row_mem[row_s1] <= {(cnt_cur == '0) ? total_s1 : first_rd, cnt_nxt};
		row_rd_q <= row_mem[bcsr_pkg::RIDX_W'(r.row)];
	end

	always_ff @(posedge clk) begin
		vld_rd_q <= row_ok && row_vld_q[bcsr_pkg::RIDX_W'(r.row)];
		row_s1   <= bcsr_pkg::RIDX_W'(r.row);
		total_s1 <= bcsr_pkg::BIDX_W'(total_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bcsr_pkg::S_IDLE:   if (acc && r.op == bcsr_pkg::OP_LOOKUP) state_d = bcsr_pkg::S_ROWRD;
			bcsr_pkg::S_ROWRD:  state_d = bcsr_pkg::S_SEARCH;
			bcsr_pkg::S_SEARCH: state_d = (lo_q < hi_q) ? bcsr_pkg::S_COLRD : bcsr_pkg::S_OUT;
			bcsr_pkg::S_COLRD:  state_d = (col_rd_q == key_q) ? bcsr_pkg::S_ELRD
				: bcsr_pkg::S_SEARCH;
			bcsr_pkg::S_ELRD:   state_d = bcsr_pkg::S_ELEM;
			bcsr_pkg::S_ELEM:   state_d = bcsr_pkg::S_OUT;
			bcsr_pkg::S_OUT: begin
				if (rsp.ready)
					state_d = (out_q.status == bcsr_pkg::ST_HIT && !out_q.last)
						? bcsr_pkg::S_ELEM : bcsr_pkg::S_IDLE;
			end
			default:            state_d = bcsr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bcsr_pkg::S_IDLE;
			total_q   <= '0;
			fill_q    <= '0;
			out_v_q   <= 1'b0;
			commit_s1 <= 1'b0;
			row_vld_q <= '0;
		end else begin
			state_q   <= state_d;
			commit_s1 <= commit && row_ok;
			if (commit_s1) row_vld_q[row_s1] <= 1'b1;
			if (acc && r.op == bcsr_pkg::OP_PUSH && !full) begin
				if (commit) begin
					fill_q  <= '0;
					total_q <= total_q + 1'b1;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if ((acc && r.op == bcsr_pkg::OP_PUSH && full) || state_q == bcsr_pkg::S_ELEM
					|| (state_q == bcsr_pkg::S_SEARCH && !(lo_q < hi_q)))
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;
		end
	end

	// search and output datapath
	always_ff @(posedge clk) begin
		if (acc)
			key_q <= r.col;
		if (acc && r.op == bcsr_pkg::OP_PUSH && full) begin
			out_q <= '{status: bcsr_pkg::ST_OVF, block_index: '0, elem_index: '0,
				elem_value: '0, last: 1'b1};
		end
		case (state_q)
			bcsr_pkg::S_ROWRD: begin
				lo_q <= (cnt_cur == '0) ? '0 : SRCH_W_ext(first_rd);
				hi_q <= (cnt_cur == '0) ? '0 : hi_calc;
			end
			bcsr_pkg::S_SEARCH: begin
				if (!(lo_q < hi_q))
					out_q <= '{status: bcsr_pkg::ST_MISS, block_index: '0, elem_index: '0,
						elem_value: '0, last: 1'b1};
			end
			bcsr_pkg::S_COLRD: begin
				if (col_rd_q < key_q) lo_q <= mid + 1'b1;
				else if (col_rd_q > key_q) hi_q <= mid;
				else begin
					hit_q   <= bcsr_pkg::BADR_W'(mid);
					eaddr_q <= bcsr_pkg::EADR_W'(32'(mid) * bcsr_pkg::BLK_ELEMS);
					eidx_q  <= '0;
				end
			end
			bcsr_pkg::S_ELEM: begin
				out_q <= '{status: bcsr_pkg::ST_HIT, block_index: bcsr_pkg::BIDX_W'(hit_q),
					elem_index: eidx_q, elem_value: elem_rd_q,
					last: 32'(eidx_q) == bcsr_pkg::BLK_ELEMS - 1};
				eaddr_q <= eaddr_q + 1'b1;
				eidx_q  <= eidx_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/bcsr_checker.sv =====
// ----------------------------------------------------------------------------
// bcsr_checker
// Port-level checks of the lookup unit, bound to the lookup unit module.
// ----------------------------------------------------------------------------
module bcsr_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input bcsr_pkg::rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response dropped while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.status == bcsr_pkg::ST_HIT
			|| rsp_data.status == bcsr_pkg::ST_MISS
			|| rsp_data.status == bcsr_pkg::ST_OVF)
		else $error("bad status code");

	a_miss_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != bcsr_pkg::ST_HIT |-> rsp_data.last)
		else $error("miss or overflow without last");

	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(req_valid && req_ready))
		else $error("request taken while response pending");

endmodule

bind bcsr_block_store_lookup_unit bcsr_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== test/bcsr_block_store_lookup_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcsr_block_store_lookup_unit_tb
// Pushes blocks row by row with ascending columns and looks them up, hits and
// misses. Every response is checked against an in-bench model of the block
// store. Both channels idle at random.
// ----------------------------------------------------------------------------
module bcsr_block_store_lookup_unit_tb;

	logic clk;
	logic arst_n;
	bit failed;
	bit quiet;
	int unsigned cycles;

	bcsr_if #(.T(bcsr_pkg::req_t)) req ();
	bcsr_if #(.T(bcsr_pkg::rsp_t)) rsp ();

	bcsr_block_store_lookup_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	logic [bcsr_pkg::BIDX_W-1:0] first_blk [bcsr_pkg::NUM_BLOCK_ROWS];
	logic [bcsr_pkg::CNT_W-1:0]  row_cnt [bcsr_pkg::NUM_BLOCK_ROWS];
	logic [bcsr_pkg::COL_W-1:0]  blk_col [bcsr_pkg::STORE_BLOCKS];
	logic [bcsr_pkg::VAL_W-1:0]  elems [bcsr_pkg::STORE_BLOCKS*bcsr_pkg::BLK_ELEMS];
	int unsigned                 blocks;
	int unsigned                 fill;
	bcsr_pkg::rsp_t              pending_rsp [$];

	typedef struct {
		logic                       op;
		logic [bcsr_pkg::ROW_W-1:0] row;
		logic [bcsr_pkg::COL_W-1:0] col;
		logic [bcsr_pkg::VAL_W-1:0] value;
		bit                         fixed;
		logic [1:0]                 status;
	} step_t;

	step_t steps [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bcsr_pkg::rsp_t mk_rsp(logic [1:0] s, int unsigned b, int unsigned e,
			logic [bcsr_pkg::VAL_W-1:0] v, logic l);
		bcsr_pkg::rsp_t r;
		r.status = s;
		r.block_index = b[bcsr_pkg::BIDX_W-1:0];
		r.elem_index = e[bcsr_pkg::EIDX_W-1:0];
		r.elem_value = v;
		r.last = l;
		return r;
	endfunction

	task automatic store_step(input bcsr_pkg::req_t q);
		int unsigned lo, hi, mid;
		if (q.op == bcsr_pkg::OP_PUSH) begin
			if (blocks >= bcsr_pkg::STORE_BLOCKS) begin
				pending_rsp.push_back(mk_rsp(bcsr_pkg::ST_OVF, 0, 0, '0, 1'b1));
				return;
			end
			elems[blocks*bcsr_pkg::BLK_ELEMS + fill] = q.value;
			fill++;
			if (fill == bcsr_pkg::BLK_ELEMS) begin
				fill = 0;
				blk_col[blocks] = q.col;
				if (row_cnt[q.row] == 0)
					first_blk[q.row] = blocks[bcsr_pkg::BIDX_W-1:0];
				if (row_cnt[q.row] != bcsr_pkg::COUNT_MAX)
					row_cnt[q.row]++;
				blocks++;
			end
			return;
		end
		if (row_cnt[q.row] != 0) begin
			lo = first_blk[q.row];
			hi = lo + row_cnt[q.row];
			if (hi > blocks)
				hi = blocks;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (blk_col[mid] < q.col)
					lo = mid + 1;
				else if (blk_col[mid] > q.col)
					hi = mid;
				else begin
					for (int i = 0; i < bcsr_pkg::BLK_ELEMS; i++)
						pending_rsp.push_back(mk_rsp(bcsr_pkg::ST_HIT, mid, i,
							elems[mid*bcsr_pkg::BLK_ELEMS + i],
							i == bcsr_pkg::BLK_ELEMS - 1));
					return;
				end
			end
		end
		pending_rsp.push_back(mk_rsp(bcsr_pkg::ST_MISS, 0, 0, '0, 1'b1));
	endtask

	task automatic send(input bcsr_pkg::req_t q, input bit fixed, input logic [1:0] st);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.data <= q;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		store_step(q);
		if (fixed && pending_rsp.size() != 0 && pending_rsp[pending_rsp.size()-1].status != st)
		begin
			$error("status: expected %0d, actual %0d", st,
				pending_rsp[pending_rsp.size()-1].status);
			failed = 1'b1;
		end
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	task automatic append_block(input logic [bcsr_pkg::ROW_W-1:0] r,
			input logic [bcsr_pkg::COL_W-1:0] c);
		bcsr_pkg::req_t q;
		for (int i = 0; i < bcsr_pkg::BLK_ELEMS; i++) begin
			q.op = bcsr_pkg::OP_PUSH;
			q.row = (i == bcsr_pkg::BLK_ELEMS - 1) ? r : bcsr_pkg::ROW_W'($urandom);
			q.col = (i == bcsr_pkg::BLK_ELEMS - 1) ? c : bcsr_pkg::COL_W'($urandom);
			q.value = {$urandom, $urandom};
			send(q, 1'b0, bcsr_pkg::ST_HIT);
		end
	endtask

	task automatic lookup(input logic [bcsr_pkg::ROW_W-1:0] r,
			input logic [bcsr_pkg::COL_W-1:0] c);
		bcsr_pkg::req_t q;
		q.op = bcsr_pkg::OP_LOOKUP;
		q.row = r;
		q.col = c;
		q.value = {$urandom, $urandom};
		send(q, 1'b0, bcsr_pkg::ST_HIT);
	endtask

	always @(posedge clk) begin
		bcsr_pkg::rsp_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp.data;
			if (pending_rsp.size() == 0) begin
				$error("unexpected response status %0d", got.status);
				failed = 1'b1;
			end else begin
				want = pending_rsp.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					failed = 1'b1;
				end
				if (got.block_index !== want.block_index) begin
					$error("block_index: expected %0d, actual %0d",
						want.block_index, got.block_index);
					failed = 1'b1;
				end
				if (got.elem_index !== want.elem_index) begin
					$error("elem_index: expected %0d, actual %0d",
						want.elem_index, got.elem_index);
					failed = 1'b1;
				end
				if (got.elem_value !== want.elem_value) begin
					$error("elem_value: expected %h, actual %h",
						want.elem_value, got.elem_value);
					failed = 1'b1;
				end
				if (got.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, got.last);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		int gap;
		rsp.ready = 1'b0;
		@(negedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 19);
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(negedge clk);
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic step_t row_of(logic op, int r, int c, logic [bcsr_pkg::VAL_W-1:0] v,
			bit fx, logic [1:0] st);
		step_t s;
		s.op = op;
		s.row = r[bcsr_pkg::ROW_W-1:0];
		s.col = c[bcsr_pkg::COL_W-1:0];
		s.value = v;
		s.fixed = fx;
		s.status = st;
		return s;
	endfunction

	initial begin
		bcsr_pkg::req_t q;
		int r, c, n;
		arst_n = 1'b0;
		failed = 1'b0;
		quiet = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		blocks = 0;
		fill = 0;
		foreach (row_cnt[i])
			row_cnt[i] = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty store misses, blocks at rows and columns 0 and 63, their lookups, then an open block in row 5
		steps.push_back(row_of(bcsr_pkg::OP_LOOKUP, 0, 0, '0, 1, bcsr_pkg::ST_MISS));
		steps.push_back(row_of(bcsr_pkg::OP_LOOKUP, 63, 63, {bcsr_pkg::VAL_W{1'b1}}, 1,
			bcsr_pkg::ST_MISS));
		for (int i = 0; i < bcsr_pkg::BLK_ELEMS; i++)
			steps.push_back(row_of(bcsr_pkg::OP_PUSH, 0, 0,
				(i % 2) ? {bcsr_pkg::VAL_W{1'b1}} : {bcsr_pkg::VAL_W{1'b0}}, 0,
				bcsr_pkg::ST_HIT));
		for (int i = 0; i < bcsr_pkg::BLK_ELEMS; i++)
			steps.push_back(row_of(bcsr_pkg::OP_PUSH, 63, 63, {$urandom, $urandom}, 0,
				bcsr_pkg::ST_HIT));
		steps.push_back(row_of(bcsr_pkg::OP_LOOKUP, 0, 0, '0, 0, bcsr_pkg::ST_HIT));
		steps.push_back(row_of(bcsr_pkg::OP_LOOKUP, 63, 63, '0, 0, bcsr_pkg::ST_HIT));
		steps.push_back(row_of(bcsr_pkg::OP_LOOKUP, 0, 63, '0, 1, bcsr_pkg::ST_MISS));
		steps.push_back(row_of(bcsr_pkg::OP_PUSH, 5, 5, {bcsr_pkg::VAL_W{1'b1}}, 0,
			bcsr_pkg::ST_HIT));
		steps.push_back(row_of(bcsr_pkg::OP_LOOKUP, 5, 5, '0, 1, bcsr_pkg::ST_MISS));
		foreach (steps[i]) begin
			q.op = steps[i].op;
			q.row = steps[i].row;
			q.col = steps[i].col;
			q.value = steps[i].value;
			send(q, steps[i].fixed, steps[i].status);
		end
		// complete the open block in row 5, column 5
		for (int i = 1; i < bcsr_pkg::BLK_ELEMS; i++) begin
			q.op = bcsr_pkg::OP_PUSH;
			q.row = bcsr_pkg::ROW_W'(5);
			q.col = bcsr_pkg::COL_W'(5);
			q.value = {$urandom, $urandom};
			send(q, 1'b0, bcsr_pkg::ST_HIT);
		end
		lookup(bcsr_pkg::ROW_W'(5), bcsr_pkg::COL_W'(5));

		// hold off until every response has drained
		drain();

		// rows 6 to 19, ascending columns, with lookups interleaved
		for (r = 6; r < 20; r++) begin
			c = $urandom_range(0, 3);
			n = $urandom_range(0, 3);
			for (int b = 0; b < n; b++) begin
				append_block(bcsr_pkg::ROW_W'(r), bcsr_pkg::COL_W'(c));
				if ($urandom_range(0, 2) == 0)
					lookup(bcsr_pkg::ROW_W'($urandom_range(0, 63)),
						bcsr_pkg::COL_W'($urandom_range(0, 63)));
				c += $urandom_range(1, 6);
				if (c > 63)
					break;
			end
			repeat ($urandom_range(1, 4))
				lookup(bcsr_pkg::ROW_W'($urandom_range(0, 1) ? r : $urandom_range(0, 63)),
					bcsr_pkg::COL_W'($urandom_range(0, 1) ? c - 1 : $urandom_range(0, 63)));
			if (r == 15)
				quiet = 1'b1;
		end

		lookup(bcsr_pkg::ROW_W'(63), bcsr_pkg::COL_W'(63));
		lookup(bcsr_pkg::ROW_W'(8), bcsr_pkg::COL_W'(0));
		lookup(bcsr_pkg::ROW_W'(0), bcsr_pkg::COL_W'(0));

		drain();
		repeat (40) @(negedge clk);
		if (!failed)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bcsr_pkg.sv
rtl/bcsr_if.sv
rtl/bcsr_block_store_lookup_unit.sv
rtl/bcsr_checker.sv
test/bcsr_block_store_lookup_unit_tb.sv
